// ===== src/ccalc_pkg.sv =====
// Shared constants for the clock divider setting calculator.
package ccalc_pkg;
  localparam int unsigned FreqW  = 32;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned FdivW  = 28;
  localparam int unsigned HalfW  = 29;
  localparam int unsigned PerW   = 30;
  localparam int unsigned EdW    = 7;
  localparam int unsigned ProdW  = 36;
  localparam int unsigned SplitW = 17;
  localparam int unsigned RecipW = 33;
  localparam int unsigned RecipK = 37;
  localparam int unsigned MulW   = SplitW + RecipW;
  localparam int unsigned SumW   = MulW + SplitW;

  localparam logic [FreqW-1:0]  FreqMax     = 32'd250000000;
  localparam logic [FreqW-1:0]  FreqMin     = 32'd1;
  localparam logic [PerW-1:0]   NsPerSec    = 30'd1000000000;
  localparam logic [ProdW-1:0]  NsPerTick   = 36'd500000000;
  localparam logic [EdW-1:0]    Percent     = 7'd100;
  localparam logic [DutyW-1:0]  PercentIn   = 8'd100;
  localparam logic [EdW-1:0]    DutyDefault = 7'd50;
  // ceil(2^37 / 25)
  localparam logic [RecipW-1:0] Recip25     = 33'd5497558139;
endpackage

// ===== src/clock_divider_setting_calc.sv =====
// Clock divider setting calculator: pipelined period, width and actual-value datapath.
// Order: period divider, stages A, M, H and B, duty and frequency dividers, output register.
// Throughput: one item per cycle; busy is always low, as every divider is fully pipelined.
// The receiver cannot stall, so every stage advances on every clock.
// Reset (rst_n, synchronous) drops all items in flight; results never appear for them.
module clock_divider_setting_calc
  import ccalc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [FreqW-1:0] in_requested_freq,
  input  logic [DutyW-1:0] in_requested_duty,
  output logic             out_strobe,
  output logic [HalfW-1:0] out_high_width,
  output logic [HalfW-1:0] out_low_width,
  output logic [PerW-1:0]  out_actual_period_ns,
  output logic [FdivW-1:0] out_actual_freq,
  output logic [EdW-1:0]   out_actual_duty,
  output logic             out_exact_match,
  output logic             out_duty_valid
);
  // Clamp frequency and duty on entry.
  logic [FreqW-1:0] f_cl;
  logic [EdW-1:0]   d_eff;

  always_comb begin
    priority if (in_requested_freq > FreqMax) begin
      f_cl = FreqMax;
    end else if (in_requested_freq < FreqMin) begin
      f_cl = FreqMin;
    end else begin
      f_cl = in_requested_freq;
    end
    if (in_requested_duty == '0 || in_requested_duty >= PercentIn) begin
      d_eff = DutyDefault;
    end else begin
      d_eff = in_requested_duty[EdW-1:0];
    end
  end

  assign busy = 1'b0;

  // Period divider: 1e9 / f.
  logic            p_vld;
  logic [PerW-1:0] p_quo;
  logic [EdW-1:0]  p_d;

  ccalc_div #(.NW(PerW), .DW(FdivW), .PW(EdW)) u_div_period (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_num   (NsPerSec),
    .in_den   (f_cl[FdivW-1:0]),
    .in_pay   (d_eff),
    .out_valid(p_vld),
    .out_quo  (p_quo),
    .out_pay  (p_d)
  );

  // Stage A: halve the period and scale by duty.
  logic             a_vld_r;
  logic [HalfW-1:0] a_half_r;
  logic [ProdW-1:0] a_prod_r;
  logic [EdW-1:0]   a_d_r;
  logic [PerW-1:0]  a_per_r;
  logic [HalfW-1:0] p_half;

  assign p_half = p_quo[PerW-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_half_r <= p_half;
    a_prod_r <= ProdW'(p_half) * ProdW'(p_d);
    a_d_r    <= p_d;
    a_per_r  <= p_quo;
  end

  // High width: half * d / 100 by reciprocal multiplication. Drop the two low
  // bits of the product (x / 100 equals (x / 4) / 25), multiply each 17-bit
  // slice by ceil(2^37 / 25), then sum the slices and keep bits 37 and up.
  // Exact for any product below 2^36.
  logic             m_vld_r;
  logic [MulW-1:0]  m_lo_r;
  logic [MulW-1:0]  m_hi_r;
  logic [HalfW-1:0] m_half_r;
  logic [EdW-1:0]   m_d_r;
  logic [PerW-1:0]  m_per_r;
  logic [SumW-1:0]  m_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_lo_r   <= MulW'(a_prod_r[SplitW+1:2]) * MulW'(Recip25);
    m_hi_r   <= MulW'(a_prod_r[ProdW-1:SplitW+2]) * MulW'(Recip25);
    m_half_r <= a_half_r;
    m_d_r    <= a_d_r;
    m_per_r  <= a_per_r;
  end

  assign m_sum = {m_hi_r, {SplitW{1'b0}}} + SumW'(m_lo_r);

  // Stage H: hold the high width with half, duty and period alongside.
  logic             h_vld_r;
  logic [HalfW-1:0] h_hi_r;
  logic [HalfW-1:0] h_half_r;
  logic [EdW-1:0]   h_d_r;
  logic [PerW-1:0]  h_per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    h_hi_r   <= m_sum[RecipK+HalfW-1:RecipK];
    h_half_r <= m_half_r;
    h_d_r    <= m_d_r;
    h_per_r  <= m_per_r;
  end

  // Stage B: form the low width and the scaled high width.
  logic             b_vld_r;
  logic [HalfW-1:0] b_hi_r;
  logic [HalfW-1:0] b_lo_r;
  logic [HalfW-1:0] b_half_r;
  logic [ProdW-1:0] b_prod_r;
  logic [EdW-1:0]   b_d_r;
  logic [PerW-1:0]  b_per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_hi_r   <= h_hi_r;
    b_lo_r   <= h_half_r - h_hi_r;
    b_half_r <= h_half_r;
    b_prod_r <= ProdW'(h_hi_r) * ProdW'(Percent);
    b_d_r    <= h_d_r;
    b_per_r  <= h_per_r;
  end

  // Actual duty and actual frequency dividers run side by side.
  localparam int unsigned Pay3W = 3 * HalfW + EdW + PerW;
  logic             u_vld;
  logic [ProdW-1:0] u_quo;
  logic [Pay3W-1:0] u_pay;
  logic [HalfW-1:0] u_hi;
  logic [HalfW-1:0] u_lo;
  logic [HalfW-1:0] u_half;
  logic [EdW-1:0]   u_d;
  logic [PerW-1:0]  u_per;
  logic             fq_vld;
  logic [ProdW-1:0] fq_quo;
  logic             fq_pay;

  ccalc_div #(.NW(ProdW), .DW(HalfW), .PW(Pay3W)) u_div_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (b_vld_r),
    .in_num   (b_prod_r),
    .in_den   (b_half_r),
    .in_pay   ({b_hi_r, b_lo_r, b_half_r, b_d_r, b_per_r}),
    .out_valid(u_vld),
    .out_quo  (u_quo),
    .out_pay  (u_pay)
  );

  // 1e9 / (2 * half) equals 5e8 / half.
  ccalc_div #(.NW(ProdW), .DW(HalfW), .PW(1)) u_div_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (b_vld_r),
    .in_num   (NsPerTick),
    .in_den   (b_half_r),
    .in_pay   (1'b0),
    .out_valid(fq_vld),
    .out_quo  (fq_quo),
    .out_pay  (fq_pay)
  );

  assign {u_hi, u_lo, u_half, u_d, u_per} = u_pay;

  // Output stage: flags and result registers.
  logic            o_vld_r;
  logic [PerW-1:0] act_per;
  logic [EdW-1:0]  act_duty;

  assign act_per  = {u_half, 1'b0};
  assign act_duty = u_quo[EdW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= u_vld & fq_vld & ~fq_pay;
    end
  end

  always_ff @(posedge clk) begin
    out_high_width       <= u_hi;
    out_low_width        <= u_lo;
    out_actual_period_ns <= act_per;
    out_actual_freq      <= fq_quo[FdivW-1:0];
    out_actual_duty      <= act_duty;
    out_exact_match      <= (u_per == act_per) && (u_d == act_duty);
    out_duty_valid       <= (act_duty != '0) && (act_duty < Percent);
  end

  assign out_strobe = o_vld_r;
endmodule

// ===== src/ccalc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module ccalc_div #(
  parameter int unsigned NW = 36,
  parameter int unsigned DW = 29,
  parameter int unsigned PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);
  logic          vld_r [0:NW];
  logic [DW-1:0] rem_r [0:NW];
  logic [NW-1:0] num_r [0:NW];
  logic [NW-1:0] quo_r [0:NW];
  logic [DW-1:0] den_r [0:NW];
  logic [PW-1:0] pay_r [0:NW];

  assign vld_r[0] = in_valid;
  assign rem_r[0] = '0;
  assign num_r[0] = in_num;
  assign quo_r[0] = '0;
  assign den_r[0] = in_den;
  assign pay_r[0] = in_pay;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] part;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      part = {rem_r[i], num_r[i][NW-1]};
      diff = part - {1'b0, den_r[i]};
      ge   = (part >= {1'b0, den_r[i]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? diff[DW-1:0] : part[DW-1:0];
      num_r[i+1] <= num_r[i] << 1;
      quo_r[i+1] <= {quo_r[i][NW-2:0], ge};
      den_r[i+1] <= den_r[i];
      pay_r[i+1] <= pay_r[i];
    end
  end

  assign out_valid = vld_r[NW];
  assign out_quo   = quo_r[NW];
  assign out_pay   = pay_r[NW];
endmodule

// ===== bench/clock_divider_setting_calc_tb.sv =====
// Testbench for the clock divider setting calculator: directed and random requests.
module clock_divider_setting_calc_tb
  import ccalc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Margin beyond the pipeline depth, allowed when draining.
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [HalfW-1:0] high_width;
    logic [HalfW-1:0] low_width;
    logic [PerW-1:0]  actual_period;
    logic [FdivW-1:0] freq;
    logic [EdW-1:0]   duty;
    logic             exact_match;
    logic             duty_valid;
  } setting_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [FreqW-1:0] in_requested_freq;
  logic [DutyW-1:0] in_requested_duty;
  logic             out_strobe;
  logic [HalfW-1:0] out_high_width;
  logic [HalfW-1:0] out_low_width;
  logic [PerW-1:0]  out_actual_period_ns;
  logic [FdivW-1:0] out_actual_freq;
  logic [EdW-1:0]   out_actual_duty;
  logic             out_exact_match;
  logic             out_duty_valid;

  setting_t    pending_settings[$];
  int unsigned mismatch_count;
  bit          allow_gaps;

  clock_divider_setting_calc DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_requested_freq    (in_requested_freq),
    .in_requested_duty    (in_requested_duty),
    .out_strobe           (out_strobe),
    .out_high_width       (out_high_width),
    .out_low_width        (out_low_width),
    .out_actual_period_ns (out_actual_period_ns),
    .out_actual_freq      (out_actual_freq),
    .out_actual_duty      (out_actual_duty),
    .out_exact_match      (out_exact_match),
    .out_duty_valid       (out_duty_valid)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Work out the divider setting for one request, in exact integer arithmetic.
  function automatic setting_t calc_setting(logic [FreqW-1:0] freq_hz,
                                            logic [DutyW-1:0] duty_pc);
    longint unsigned f;
    longint unsigned d;
    longint unsigned period;
    longint unsigned half;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned act_period;
    longint unsigned act_duty;
    setting_t s;
    f = freq_hz;
    d = duty_pc;
    // Clamp the frequency into the supported range.
    if (f > FreqMax) f = FreqMax;
    if (f < FreqMin) f = FreqMin;
    // Out-of-range duty falls back to half and half.
    if (d == 0 || d >= 100) d = 50;
    period     = 64'd1000000000 / f;
    half       = period / 2;
    hi         = (half * d) / 100;
    lo         = half - hi;
    act_period = (hi + lo) * 2;
    act_duty   = (hi * 100) / (hi + lo);
    s.high_width    = hi[HalfW-1:0];
    s.low_width     = lo[HalfW-1:0];
    s.actual_period = act_period[PerW-1:0];
    s.freq          = FdivW'(64'd1000000000 / act_period);
    s.duty          = act_duty[EdW-1:0];
    s.exact_match   = (period == act_period) && (d == act_duty);
    s.duty_valid    = (act_duty > 0) && (act_duty < 100);
    return s;
  endfunction

  // Hold the request on the ports until the block accepts it, with an optional gap first.
  task automatic send_request(logic [FreqW-1:0] freq_hz, logic [DutyW-1:0] duty_pc);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_requested_freq <= freq_hz;
    in_requested_duty <= duty_pc;
    do @(posedge clk); while (busy);
    pending_settings.push_back(calc_setting(freq_hz, duty_pc));
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  // Pause until every outstanding result has come back.
  task automatic wait_drained();
    stop_sending();
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    setting_t want;
    if (rst_n && out_strobe) begin
      if (pending_settings.size() == 0) begin
        $display("%0t: unexpected result high %0d low %0d", $time, out_high_width,
                 out_low_width);
        mismatch_count++;
      end else begin
        want = pending_settings.pop_front();
        if (out_high_width !== want.high_width) begin
          $display("%0t: high_width expected %0d actual %0d", $time, want.high_width,
                   out_high_width);
          mismatch_count++;
        end
        if (out_low_width !== want.low_width) begin
          $display("%0t: low_width expected %0d actual %0d", $time, want.low_width,
                   out_low_width);
          mismatch_count++;
        end
        if (out_actual_period_ns !== want.actual_period) begin
          $display("%0t: actual period expected %0d actual %0d", $time,
                   want.actual_period, out_actual_period_ns);
          mismatch_count++;
        end
        if (out_actual_freq !== want.freq) begin
          $display("%0t: actual_freq expected %0d actual %0d", $time, want.freq,
                   out_actual_freq);
          mismatch_count++;
        end
        if (out_actual_duty !== want.duty) begin
          $display("%0t: actual_duty expected %0d actual %0d", $time, want.duty,
                   out_actual_duty);
          mismatch_count++;
        end
        if (out_exact_match !== want.exact_match) begin
          $display("%0t: exact_match expected %0b actual %0b", $time, want.exact_match,
                   out_exact_match);
          mismatch_count++;
        end
        if (out_duty_valid !== want.duty_valid) begin
          $display("%0t: duty_valid expected %0b actual %0b", $time, want.duty_valid,
                   out_duty_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Edges of both fields and each named special case.
  task automatic test_directed();
    send_request(32'd0, 8'd50);            // zero frequency becomes 1 Hz
    send_request(32'd1, 8'd1);
    send_request(32'd250000000, 8'd50);    // fastest setting, tiny half period
    send_request(32'd250000000, 8'd1);     // high width truncates to zero
    send_request(32'd250000000, 8'd99);
    send_request(32'd250000001, 8'd50);    // above maximum, clamped
    send_request(32'hFFFFFFFF, 8'd255);    // all ones on both fields
    send_request(32'd1000000, 8'd0);       // zero duty falls back to half
    send_request(32'd1000000, 8'd100);
    send_request(32'd1000000, 8'd25);      // exact setting
    send_request(32'd3, 8'd33);            // odd period
    send_request(32'd7, 8'd99);
    send_request(32'd166666666, 8'd50);    // even period near the top
    send_request(32'd125000000, 8'd75);
    send_request(32'd2, 8'd128);
    send_request(32'h80000000, 8'd99);
    send_request(32'd10000, 8'd10);
    send_request(32'd100000000, 8'd33);
    wait_drained();
  endtask

  function automatic logic [FreqW-1:0] pick_freq();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(249000000, 251000000);
      3: return $urandom_range(1000000, 250000000);
      default: return $urandom_range(1, 10000000);
    endcase
  endfunction

  function automatic logic [DutyW-1:0] pick_duty();
    if ($urandom_range(0, 7) == 0) return DutyW'($urandom_range(0, 255));
    return DutyW'($urandom_range(1, 99));
  endfunction

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_request(pick_freq(), pick_duty());
    stop_sending();
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_requested_freq = '0;
    in_requested_duty = '0;
    mismatch_count    = 0;
    allow_gaps        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    allow_gaps = 1'b1;
    test_random(450);
    wait_drained();
    test_random(300);
    // Finish with back-to-back requests.
    allow_gaps = 1'b0;
    test_random(200);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== clock_divider_setting_calc.f =====
src/ccalc_pkg.sv
src/ccalc_div.sv
src/clock_divider_setting_calc.sv
bench/clock_divider_setting_calc_tb.sv
